// ===== hdl/mdep_pkg.sv =====
// Package: shared types, codes and the drum note map for the MIDI drum event parser.
package mdep_pkg;

  // Parser phase codes; codes beyond these are handled as a delta byte.
  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_META_TYPE = 4'd2,
    PH_META_LEN  = 4'd3,
    PH_META_SKIP = 4'd4,
    PH_SKIP2     = 4'd5,
    PH_SKIP1     = 4'd6,
    PH_NOTE_KEY  = 4'd7,
    PH_NOTE_VEL  = 4'd8
  } phase_t;

  localparam logic [7:0]  STATUS_META    = 8'hFF;
  localparam logic [7:0]  STATUS_CTRL    = 8'hB9;
  localparam logic [7:0]  STATUS_PROG    = 8'hC9;
  localparam logic [7:0]  STATUS_NOTE    = 8'h99;
  localparam logic [7:0]  META_SETTING   = 8'h21;
  localparam logic [7:0]  META_LEN_ONE   = 8'h01;
  localparam logic [27:0] DELTA_MAX      = 28'h0FFF_FFFF;
  localparam logic [27:0] DELTA_LIMIT    = DELTA_MAX >> 7;
  localparam logic [31:0] TICK_OUT_MAX   = 32'hFFFF_FFFF;

  localparam logic [3:0] DRUM_NONE   = 4'd0;
  localparam logic [3:0] DRUM_SNARE  = 4'd1;
  localparam logic [3:0] DRUM_TOM_LO = 4'd2;
  localparam logic [3:0] DRUM_TOM_MD = 4'd3;
  localparam logic [3:0] DRUM_TOM_HI = 4'd4;
  localparam logic [3:0] DRUM_HH_CL  = 4'd5;
  localparam logic [3:0] DRUM_RIDE   = 4'd6;
  localparam logic [3:0] DRUM_CRASH1 = 4'd7;
  localparam logic [3:0] DRUM_CRASH2 = 4'd8;
  localparam logic [3:0] DRUM_BASS   = 4'd10;
  localparam logic [3:0] DRUM_HH_OP  = 4'd11;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       track_end;
  } byte_item_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  drum_code;
    logic [31:0] ticks_since_hit;
    logic        is_end;
    logic        setting_flag;
  } result_t;

  // Parser state other than the tick total, whose width is a parameter.
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  running_status;
    logic [27:0] delta_accum;
    logic [7:0]  meta_kind;
    logic [7:0]  meta_remaining;
    logic [7:0]  held_note;
    logic        setting_seen;
  } parse_state_t;

  function automatic logic [3:0] drum_map(input logic [7:0] note);
    logic [3:0] code;
    case (note)
      8'd38:   code = DRUM_SNARE;
      8'd41:   code = DRUM_TOM_LO;
      8'd45:   code = DRUM_TOM_MD;
      8'd47:   code = DRUM_TOM_HI;
      8'd48:   code = DRUM_TOM_HI;
      8'd50:   code = DRUM_TOM_HI;
      8'd42:   code = DRUM_HH_CL;
      8'd51:   code = DRUM_RIDE;
      8'd49:   code = DRUM_CRASH1;
      8'd57:   code = DRUM_CRASH2;
      8'd36:   code = DRUM_BASS;
      8'd46:   code = DRUM_HH_OP;
      default: code = DRUM_NONE;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/mdep_ifs.sv =====
// Interfaces: track byte channel and result channel of the MIDI drum event parser.
interface mdep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_end;

  modport source (output valid, output track_byte, output track_end, input ready);
  modport sink   (input valid, input track_byte, input track_end, output ready);
endinterface

interface mdep_result_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  drum_code;
  logic [31:0] ticks_since_hit;
  logic        is_end;
  logic        setting_flag;

  modport source (output valid, output hit, output drum_code, output ticks_since_hit,
                  output is_end, output setting_flag, input ready);
  modport sink   (input valid, input hit, input drum_code, input ticks_since_hit,
                  input is_end, input setting_flag, output ready);
endinterface

// ===== hdl/mdep_in_stage.sv =====
// Input register: holds one track byte until the parse stage takes it.
module mdep_in_stage (
  input  logic               clk,
  input  logic               rst,
  mdep_byte_if.sink          track,
  input  logic               take,
  output logic               q_valid,
  output mdep_pkg::byte_item_t q
);
  import mdep_pkg::*;

  assign track.ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (track.valid && track.ready) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (track.valid && track.ready) begin
      q.track_byte <= track.track_byte;
      q.track_end  <= track.track_end;
    end
  end
endmodule

// ===== hdl/mdep_step.sv =====
// Parse step: next parser state and optional result for one track byte.
module mdep_step #(
  parameter int TICK_BITS = 32
) (
  input  mdep_pkg::parse_state_t st,
  input  logic [TICK_BITS-1:0]   tick,
  input  mdep_pkg::byte_item_t   item,
  output mdep_pkg::parse_state_t st_next,
  output logic [TICK_BITS-1:0]   tick_next,
  output logic                   emit,
  output mdep_pkg::result_t      res
);
  import mdep_pkg::*;

  localparam int SUM_W = ((TICK_BITS > 28) ? TICK_BITS : 28) + 1;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  function automatic logic [31:0] sat32(input logic [TICK_BITS-1:0] t);
    logic [63:0] ext;
    ext = 64'(t);
    return (ext > 64'(TICK_OUT_MAX)) ? TICK_OUT_MAX : ext[31:0];
  endfunction

  logic [7:0]       b;
  logic [27:0]      delta_new;
  logic [SUM_W-1:0] sum;
  logic             hit;
  logic [3:0]       code;
  logic [31:0]      hit_ticks;

  assign b = item.track_byte;
  // Saturate the delta once it would pass 28 bits.
  assign delta_new = (st.delta_accum > DELTA_LIMIT) ? DELTA_MAX
                                                    : {st.delta_accum[20:0], b[6:0]};
  assign sum = SUM_W'(tick) + SUM_W'(delta_new);

  always_comb begin
    st_next   = st;
    tick_next = tick;
    hit       = 1'b0;
    code      = DRUM_NONE;
    hit_ticks = sat32(tick);
    emit      = 1'b0;
    res       = '0;

    case (st.phase)
      PH_STATUS: begin
        if (b == STATUS_META) begin
          st_next.running_status = b;
          st_next.phase          = PH_META_TYPE;
        end else if (b == STATUS_CTRL) begin
          st_next.running_status = b;
          st_next.phase          = PH_SKIP2;
        end else if (b == STATUS_PROG) begin
          st_next.running_status = b;
          st_next.phase          = PH_SKIP1;
        end else if (b == STATUS_NOTE) begin
          st_next.running_status = b;
          st_next.phase          = PH_NOTE_KEY;
        end else if (st.running_status == STATUS_META) begin
          st_next.meta_kind = b;
          st_next.phase     = PH_META_LEN;
        end else if (st.running_status == STATUS_CTRL) begin
          st_next.phase = PH_SKIP1;
        end else if (st.running_status == STATUS_NOTE) begin
          st_next.held_note = b;
          st_next.phase     = PH_NOTE_VEL;
        end else begin
          st_next.phase = PH_DELTA;
        end
      end
      PH_META_TYPE: begin
        st_next.meta_kind = b;
        st_next.phase     = PH_META_LEN;
      end
      PH_META_LEN: begin
        st_next.meta_remaining = b;
        if (st.meta_kind == META_SETTING && b == META_LEN_ONE) begin
          st_next.setting_seen = 1'b1;
        end
        st_next.phase = (b == 8'd0) ? PH_DELTA : PH_META_SKIP;
      end
      PH_META_SKIP: begin
        st_next.meta_remaining = st.meta_remaining - 8'd1;
        if (st.meta_remaining == 8'd1) begin
          st_next.phase = PH_DELTA;
        end
      end
      PH_SKIP2: begin
        st_next.phase = PH_SKIP1;
      end
      PH_SKIP1: begin
        st_next.phase = PH_DELTA;
      end
      PH_NOTE_KEY: begin
        st_next.held_note = b;
        st_next.phase     = PH_NOTE_VEL;
      end
      PH_NOTE_VEL: begin
        if (b != 8'd0) begin
          hit       = 1'b1;
          code      = drum_map(st.held_note);
          tick_next = '0;
        end
        st_next.phase = PH_DELTA;
      end
      default: begin
        // Delta time byte, also taken for any unused phase code.
        st_next.delta_accum = delta_new;
        if (!b[7]) begin
          tick_next = (sum > SUM_W'(TICK_MAX)) ? TICK_MAX : sum[TICK_BITS-1:0];
          st_next.delta_accum = '0;
          st_next.phase       = PH_STATUS;
        end else begin
          st_next.phase = PH_DELTA;
        end
      end
    endcase

    if (item.track_end) begin
      // End byte: report the total, drop any hit, restart the parser.
      emit                = 1'b1;
      res.hit             = 1'b0;
      res.drum_code       = DRUM_NONE;
      res.ticks_since_hit = sat32(tick_next);
      res.is_end          = 1'b1;
      res.setting_flag    = st_next.setting_seen;
      st_next.phase          = PH_DELTA;
      st_next.running_status = '0;
      st_next.delta_accum    = '0;
      st_next.meta_kind      = '0;
      st_next.meta_remaining = '0;
      st_next.held_note      = '0;
      tick_next              = '0;
    end else if (hit) begin
      emit                = 1'b1;
      res.hit             = 1'b1;
      res.drum_code       = code;
      res.ticks_since_hit = hit_ticks;
      res.is_end          = 1'b0;
      res.setting_flag    = st_next.setting_seen;
    end
  end
endmodule

// ===== hdl/mdep_out_stage.sv =====
// Result register: holds one result until the sink takes it.
module mdep_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              emit,
  input  mdep_pkg::result_t d,
  output logic              free,
  mdep_result_if.source     result
);
  import mdep_pkg::*;

  result_t q;

  assign free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= emit;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      q <= d;
    end
  end

  assign result.hit             = q.hit;
  assign result.drum_code       = q.drum_code;
  assign result.ticks_since_hit = q.ticks_since_hit;
  assign result.is_end          = q.is_end;
  assign result.setting_flag    = q.setting_flag;
endmodule

// ===== hdl/midi_drum_event_parser_unit.sv =====
// Top level: MIDI drum track byte parser with registered input and result stages.
//
// Usage:
//   track  - sink channel, one MIDI track byte per transaction; track_end marks
//            the final byte of a track.
//   result - source channel, zero or one transaction per byte: a drum hit
//            (hit=1, drum_code, ticks_since_hit) or an end-of-track report
//            (is_end=1, ticks total as it stands). setting_flag shows the
//            sticky meta 0x21 flag.
//   Path: the accepting edge loads a byte into the input register; the
//   parse step then takes it once the result slot is free, loading any
//   result into the result register. Throughput: one byte per cycle while
//   no result waits on result.ready; the parse step is a single pass of
//   combinational logic, and the tick add and compare is its longest path.
//   Reset (rst, synchronous): both stages empty, parser expecting a delta
//   time, running status and tick total zero, setting flag cleared.
//   Stall: while a result waits on result.ready, the parse stage holds; the
//   input register can still take one byte if it is empty, then track.ready
//   drops.
//   An end byte restarts the parser but keeps the setting flag.
module midi_drum_event_parser_unit #(
  parameter int TICK_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  mdep_byte_if.sink     track,
  mdep_result_if.source result
);
  import mdep_pkg::*;

  logic                 in_valid;
  byte_item_t           in_item;
  logic                 out_free;
  logic                 advance;

  parse_state_t         st;
  parse_state_t         st_next;
  logic [TICK_BITS-1:0] tick_total;
  logic [TICK_BITS-1:0] tick_total_next;
  logic                 emit;
  result_t              res;

  // Advance the parse stage whenever a byte is held and the result slot frees.
  assign advance = in_valid && out_free;

  mdep_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .track   (track),
    .take    (advance),
    .q_valid (in_valid),
    .q       (in_item)
  );

  mdep_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .st        (st),
    .tick      (tick_total),
    .item      (in_item),
    .st_next   (st_next),
    .tick_next (tick_total_next),
    .emit      (emit),
    .res       (res)
  );

  // Parser state: update only when a byte actually passes the parse step.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_DELTA;
      st.running_status <= '0;
      st.delta_accum    <= '0;
      st.meta_kind      <= '0;
      st.meta_remaining <= '0;
      st.held_note      <= '0;
      st.setting_seen   <= 1'b0;
      tick_total        <= '0;
    end else if (advance) begin
      st         <= st_next;
      tick_total <= tick_total_next;
    end
  end

  mdep_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .emit   (emit),
    .d      (res),
    .free   (out_free),
    .result (result)
  );
endmodule

// ===== hdl/mdep_checker.sv =====
// Checker: port-level assertions for the MIDI drum event parser, bound to the top level.
module mdep_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [3:0]  drum_code,
  input logic [31:0] ticks_since_hit,
  input logic        is_end,
  input logic        setting_flag
);
  import mdep_pkg::*;

  // A result is either a hit or an end report, never both or neither.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit != is_end))
    else $error("result is not exactly one of hit and end");

  // Hits carry a drum code from the note map only, DRUM_NONE included.
  a_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (drum_code <= DRUM_HH_OP && drum_code != 4'd9))
    else $error("hit carries an unmapped drum code");

  // End reports carry no drum code.
  a_end_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_end) |-> (drum_code == DRUM_NONE))
    else $error("end result carries a drum code");

  // Reset empties the result stage.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(drum_code)
      && $stable(ticks_since_hit) && $stable(is_end) && $stable(setting_flag)))
    else $error("stalled result changed");
endmodule

bind midi_drum_event_parser_unit mdep_checker u_mdep_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .hit             (result.hit),
  .drum_code       (result.drum_code),
  .ticks_since_hit (result.ticks_since_hit),
  .is_end          (result.is_end),
  .setting_flag    (result.setting_flag)
);
